[sv/lz4d_pkg.sv]
package lz4d_pkg;

  // default sizing
  localparam int DefWindowBytes = 65536;
  localparam int DefMaxBurst    = 64;
  localparam int DefCountBits   = 24;

  // fixed field widths
  localparam int CapBits  = 24;
  localparam int DistBits = 16;

  // input opcodes
  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_CONT   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BUSY  = 3'd1;
  localparam logic [2:0] ST_ZERO  = 3'd2;
  localparam logic [2:0] ST_FAR   = 3'd3;
  localparam logic [2:0] ST_CAP   = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;

  // register addresses (word index)
  localparam logic REG_STREAM_MODE  = 1'b0;
  localparam logic REG_OUT_CAPACITY = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic                put;       // write one byte into history
    logic                put_copy;  // byte comes from history read
    logic [7:0]          lit;       // literal byte
    logic                clr_hist;  // drop history and block count
    logic                clr_prod;  // end of block, reset block count
    logic [DistBits-1:0] mdist;     // match distance for history read
    logic                emit;      // load output register
    logic [7:0]          e_byte;
    logic                e_valid;
    logic [2:0]          e_status;
    logic                e_pend;
    logic                e_done;
    logic                e_last;
  } lz4d_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } lz4d_stat_t;

endpackage

[sv/lz4d_datapath.sv]
module lz4d_datapath #(
  parameter int WINDOW_BYTES = lz4d_pkg::DefWindowBytes,
  parameter int COUNT_BITS   = lz4d_pkg::DefCountBits,
  parameter int AW           = $clog2(WINDOW_BYTES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lz4d_pkg::lz4d_cmd_t   cmd,
  output lz4d_pkg::lz4d_stat_t  stat,
  output logic [AW:0]           fill,
  output logic [COUNT_BITS-1:0] produced,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [7:0]            out_byte,
  output logic                  byte_valid,
  output logic [2:0]            status,
  output logic                  copy_pending,
  output logic                  block_done,
  output logic                  run_last
);
  import lz4d_pkg::*;

  localparam logic [AW:0] Window = (AW + 1)'(WINDOW_BYTES);

  logic [7:0]    ring [WINDOW_BYTES];
  logic [AW-1:0] wp;
  logic [AW:0]   wide_wp;
  logic [AW:0]   wide_dist;
  logic [AW:0]   ridx;
  logic [7:0]    rdata;
  logic [7:0]    wdata;

  // history read address, wrapping around the ring
  always_comb begin
    wide_wp   = {1'b0, wp};
    wide_dist = (AW + 1)'(cmd.mdist);
    if (wide_wp >= wide_dist) begin
      ridx = wide_wp - wide_dist;
    end else begin
      ridx = wide_wp + Window - wide_dist;
    end
  end

  assign wdata = cmd.put_copy ? rdata : cmd.lit;

  // history ring
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      ring[wp] <= wdata;
    end
    rdata <= ring[ridx[AW-1:0]];
  end

  // write pointer and fill counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_hist) begin
      wp       <= '0;
      fill     <= '0;
      produced <= '0;
    end else begin
      if (cmd.put) begin
        if ({1'b0, wp} == Window - 1'b1) begin
          wp <= '0;
        end else begin
          wp <= wp + 1'b1;
        end
        if (fill < Window) begin
          fill <= fill + 1'b1;
        end
      end
      if (cmd.clr_prod) begin
        produced <= '0;
      end else if (cmd.put && produced != '1) begin
        produced <= produced + 1'b1;
      end
    end
  end

  assign stat.out_free = !out_valid || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_byte     <= cmd.put_copy ? rdata : cmd.e_byte;
      byte_valid   <= cmd.e_valid;
      status       <= cmd.e_status;
      copy_pending <= cmd.e_pend;
      block_done   <= cmd.e_done;
      run_last     <= cmd.e_last;
    end
  end

endmodule

[sv/lz4d_ctrl.sv]
module lz4d_ctrl #(
  parameter int MAX_BURST  = lz4d_pkg::DefMaxBurst,
  parameter int COUNT_BITS = lz4d_pkg::DefCountBits,
  parameter int AW         = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_block,
  input  logic                          stream_mode,
  input  logic [lz4d_pkg::CapBits-1:0]  out_capacity,
  input  logic [AW:0]                   fill,
  input  logic [COUNT_BITS-1:0]         produced,
  input  lz4d_pkg::lz4d_stat_t          stat,
  output lz4d_pkg::lz4d_cmd_t           cmd
);
  import lz4d_pkg::*;

  localparam int CB = COUNT_BITS;
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam int XW = ((CB > CapBits) ? CB : CapBits) + 1;
  localparam int RW = (CB > AW + 1) ? CB : AW + 1;

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITEXT, PH_LIT, PH_OFFLO, PH_OFFHI, PH_MLEXT, PH_COPY, PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {S_IDLE, S_EMIT, S_RD, S_WR} state_t;

  state_t              state;
  phase_t              phase, ph_n;
  logic [3:0]          mcode, mc_n;
  logic [CB-1:0]       rem, rem_n;
  logic [DistBits-1:0] mdist, mdist_n;
  logic [BW-1:0]       cnt, n_burst;
  logic [2:0]          r_status, st_n;
  logic                r_done, done_n;
  logic                r_pend;
  logic                r_bv;
  logic [7:0]          r_byte;
  logic                r_fin, fin_end_n;

  // decode flags
  logic          accept, eob;
  logic          put_n, fin_n, fail_n, lit_known, start_m, burst_n, clr_all;
  logic [2:0]    fcode;
  logic [CB:0]   sum;
  logic [CB-1:0] sat_d;
  logic [XW-1:0] need;
  logic [RW-1:0] reach;
  logic          over_cap;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign eob      = end_of_block;

  // saturating add of an extension byte
  always_comb begin
    sum   = {1'b0, rem} + (CB + 1)'(data_byte);
    sat_d = sum[CB] ? '1 : sum[CB-1:0];
  end

  // parse one item
  always_comb begin
    ph_n      = phase;
    mc_n      = mcode;
    rem_n     = rem;
    mdist_n   = mdist;
    st_n      = ST_OK;
    done_n    = 1'b0;
    put_n     = 1'b0;
    fin_n     = 1'b0;
    fin_end_n = 1'b0;
    fail_n    = 1'b0;
    fcode     = ST_OK;
    lit_known = 1'b0;
    start_m   = 1'b0;
    burst_n   = 1'b0;
    clr_all   = 1'b0;
    n_burst   = '0;
    need      = '0;
    reach     = '0;
    over_cap  = 1'b0;

    unique case (opcode_t'(opcode))
      OP_BYTE: begin
        unique case (phase)
          PH_TOKEN: begin
            mc_n = data_byte[3:0];
            if (data_byte[7:4] == 4'hf) begin
              rem_n = CB'(15);
              if (eob) begin
                fail_n = 1'b1;
                fcode  = ST_TRUNC;
              end else begin
                ph_n = PH_LITEXT;
              end
            end else if (data_byte[7:4] == 4'h0) begin
              if (eob) fin_n = 1'b1;
              else ph_n = PH_OFFLO;
            end else begin
              rem_n     = CB'(data_byte[7:4]);
              lit_known = 1'b1;
            end
          end
          PH_LITEXT: begin
            rem_n = sat_d;
            if (data_byte == 8'hff) begin
              if (eob) begin
                fail_n = 1'b1;
                fcode  = ST_TRUNC;
              end
            end else begin
              lit_known = 1'b1;
            end
          end
          PH_LIT: begin
            put_n = 1'b1;
            rem_n = (rem != '0) ? rem - 1'b1 : rem;
            if (rem_n == '0) begin
              if (eob) fin_n = 1'b1;
              else ph_n = PH_OFFLO;
            end else if (eob) begin
              fail_n = 1'b1;
              fcode  = ST_TRUNC;
            end
          end
          PH_OFFLO: begin
            mdist_n = {8'h00, data_byte};
            if (eob) begin
              fail_n = 1'b1;
              fcode  = ST_TRUNC;
            end else begin
              ph_n = PH_OFFHI;
            end
          end
          PH_OFFHI: begin
            mdist_n = {data_byte, mdist[7:0]};
            if (mdist_n == '0) begin
              fail_n = 1'b1;
              fcode  = ST_ZERO;
            end else if (mcode == 4'hf) begin
              rem_n = CB'(19);
              if (eob) begin
                fail_n = 1'b1;
                fcode  = ST_TRUNC;
              end else begin
                ph_n = PH_MLEXT;
              end
            end else begin
              rem_n   = CB'(mcode) + CB'(4);
              start_m = 1'b1;
            end
          end
          PH_MLEXT: begin
            rem_n = sat_d;
            if (data_byte == 8'hff) begin
              if (eob) begin
                fail_n = 1'b1;
                fcode  = ST_TRUNC;
              end
            end else begin
              start_m = 1'b1;
            end
          end
          PH_COPY: begin
            fail_n = 1'b1;
            fcode  = ST_BUSY;
          end
          PH_DISCARD: begin
            st_n = mcode[2:0];
            if (eob) begin
              ph_n   = PH_TOKEN;
              mc_n   = '0;
              done_n = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_CONT: begin
        if (phase == PH_COPY) burst_n = 1'b1;
        else if (phase == PH_DISCARD) st_n = mcode[2:0];
      end
      OP_CLEAR: begin
        clr_all = 1'b1;
        ph_n    = PH_TOKEN;
        mc_n    = '0;
        rem_n   = '0;
        mdist_n = '0;
      end
      OP_UNUSED: ;
      default: ;
    endcase

    // capacity check against the new run length
    need     = XW'(produced) + XW'(rem_n);
    over_cap = need > XW'(out_capacity);
    reach    = stream_mode ? RW'(fill) : RW'(produced);

    if (lit_known) begin
      if (over_cap) begin
        fail_n = 1'b1;
        fcode  = ST_CAP;
      end else if (eob) begin
        fail_n = 1'b1;
        fcode  = ST_TRUNC;
      end else begin
        ph_n = PH_LIT;
      end
    end

    if (start_m) begin
      if (over_cap) begin
        fail_n = 1'b1;
        fcode  = ST_CAP;
      end else if (RW'(mdist_n) > reach) begin
        fail_n = 1'b1;
        fcode  = ST_FAR;
      end else begin
        mc_n    = {3'b000, eob};
        burst_n = 1'b1;
      end
    end

    // one burst of up to MAX_BURST copied bytes
    if (burst_n) begin
      n_burst = (rem_n < CB'(MAX_BURST)) ? rem_n[BW-1:0] : BW'(MAX_BURST);
      rem_n   = rem_n - CB'(n_burst);
      if (rem_n == '0) begin
        if (mc_n != '0) begin
          fin_end_n = 1'b1;
          done_n    = 1'b1;
        end
        mc_n = '0;
        ph_n = PH_TOKEN;
      end else begin
        ph_n = PH_COPY;
      end
    end

    if (fin_n) begin
      rem_n  = '0;
      mc_n   = '0;
      ph_n   = PH_TOKEN;
      done_n = 1'b1;
    end

    if (fail_n) begin
      rem_n = '0;
      st_n  = fcode;
      if (eob) begin
        ph_n   = PH_TOKEN;
        mc_n   = '0;
        done_n = 1'b1;
      end else begin
        ph_n = PH_DISCARD;
        mc_n = {1'b0, fcode};
      end
    end
  end

  // sequencer and parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_TOKEN;
      mcode    <= '0;
      rem      <= '0;
      mdist    <= '0;
      cnt      <= '0;
      r_status <= ST_OK;
      r_done   <= 1'b0;
      r_pend   <= 1'b0;
      r_bv     <= 1'b0;
      r_byte   <= '0;
      r_fin    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            phase    <= ph_n;
            mcode    <= mc_n;
            rem      <= rem_n;
            mdist    <= mdist_n;
            r_status <= st_n;
            r_done   <= done_n;
            r_pend   <= (ph_n == PH_COPY);
            r_bv     <= put_n && (opcode_t'(opcode) == OP_BYTE);
            r_byte   <= data_byte;
            r_fin    <= fin_end_n;
            cnt      <= n_burst;
            state    <= (burst_n && !fail_n) ? S_RD : S_EMIT;
          end
        end
        S_EMIT: begin
          if (stat.out_free) state <= S_IDLE;
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (stat.out_free) begin
            cnt   <= cnt - 1'b1;
            state <= (cnt == BW'(1)) ? S_IDLE : S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.mdist    = mdist;
    cmd.lit      = data_byte;
    cmd.e_status = r_status;
    cmd.e_pend   = r_pend;
    cmd.e_done   = r_done;
    unique case (state)
      S_IDLE: begin
        cmd.put      = accept && put_n;
        cmd.clr_hist = accept && (fail_n || clr_all);
        cmd.clr_prod = accept && fin_n;
      end
      S_EMIT: begin
        cmd.emit    = stat.out_free;
        cmd.e_byte  = r_bv ? r_byte : 8'h00;
        cmd.e_valid = r_bv;
        cmd.e_last  = 1'b1;
      end
      S_RD: ;
      S_WR: begin
        cmd.put      = stat.out_free;
        cmd.put_copy = 1'b1;
        cmd.emit     = stat.out_free;
        cmd.e_valid  = 1'b1;
        cmd.e_last   = (cnt == BW'(1));
        cmd.clr_prod = stat.out_free && (cnt == BW'(1)) && r_fin;
      end
      default: ;
    endcase
  end

endmodule

[sv/lz4_block_decompressor_with_history.sv]
// LZ4 block decompressor with an output history ring.
// Input channel (in_valid / in_stall): one item per transfer. opcode 0 carries
// one compressed byte, opcode 1 continues a pending match copy, opcode 2
// clears history and block state. end_of_block marks the last byte of a block.
// Output channel (out_valid / out_stall): each item gives one or more result
// transfers; run_last marks the final one of an item. A match gives up to
// MAX_BURST copied bytes per item; copy_pending asks for continue items.
// An item that gives one result goes to the emit state, which loads the
// output register when it is free; the next item can be taken once that
// result is loaded. Each copied byte takes a history read, then a write and
// output; this read and write loop on the ring sets the copy rate. One item
// is worked on at a time; in_stall stays high until its last result is
// loaded.
// When the receiver stalls, the held result stays on the outputs and the
// copy loop waits. Reset empties history, returns to token parsing, and
// sets stream_mode 0 and out_capacity to its maximum; no clearing pass.
// APB port: stream_mode at 0x0, out_capacity at 0x4.
module lz4_block_decompressor_with_history #(
  parameter int WINDOW_BYTES = lz4d_pkg::DefWindowBytes,
  parameter int MAX_BURST    = lz4d_pkg::DefMaxBurst,
  parameter int COUNT_BITS   = lz4d_pkg::DefCountBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic        end_of_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic [2:0]  status,
  output logic        copy_pending,
  output logic        block_done,
  output logic        run_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lz4d_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);

  logic               stream_mode;
  logic [CapBits-1:0] out_capacity;
  logic [AW:0]        fill;
  logic [COUNT_BITS-1:0] produced;
  lz4d_cmd_t          cmd;
  lz4d_stat_t         stat;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_mode  <= 1'b0;
      out_capacity <= '1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_STREAM_MODE:  stream_mode  <= pwdata[0];
        REG_OUT_CAPACITY: out_capacity <= pwdata[CapBits-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_STREAM_MODE:  prdata = {31'h0, stream_mode};
      REG_OUT_CAPACITY: prdata = {{(32 - CapBits){1'b0}}, out_capacity};
      default:          prdata = '0;
    endcase
  end

  lz4d_ctrl #(
    .MAX_BURST  (MAX_BURST),
    .COUNT_BITS (COUNT_BITS),
    .AW         (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .end_of_block (end_of_block),
    .stream_mode  (stream_mode),
    .out_capacity (out_capacity),
    .fill         (fill),
    .produced     (produced),
    .stat         (stat),
    .cmd          (cmd)
  );

  lz4d_datapath #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .COUNT_BITS   (COUNT_BITS),
    .AW           (AW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .fill         (fill),
    .produced     (produced),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .status       (status),
    .copy_pending (copy_pending),
    .block_done   (block_done),
    .run_last     (run_last)
  );

endmodule
